// ===== sv/rgca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgca_pkg
// shared constants, types and functions of the route great-circle accumulator
// ----------------------------------------------------------------------------
package rgca_pkg;

  localparam int ANGLE_FRAC_BITS   = 20;
  localparam int CORDIC_ITERATIONS = 24;

  localparam int LAT_W    = 28;
  localparam int LON_W    = 29;
  localparam int RADIUS_W = 24;
  localparam int SPEED_W  = 16;
  localparam int LEG_W    = 26;
  localparam int TOTAL_W  = 32;
  localparam int MAG_W    = 28;

  localparam int CORDIC_W = 34;
  localparam int OPND_W   = 33;
  localparam int PROD_W   = 2 * OPND_W;
  localparam int ROOT_N_W = 61;
  localparam int ROOT_W   = 31;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd1013453;
  localparam logic [SPEED_W-1:0]  SPEED_RESET  = 16'd500;

  localparam int HALF_TURN    = 180 * (1 << (ANGLE_FRAC_BITS + 1));
  localparam int QUARTER_TURN = 90 * (1 << (ANGLE_FRAC_BITS + 1));
  localparam int FULL_TURN    = 2 * HALF_TURN;

  localparam logic [31:0] DEG_TO_RAD_Q36 = 32'd1199381129;
  localparam logic [15:0] DR_LO          = DEG_TO_RAD_Q36[15:0];
  localparam logic [15:0] DR_HI          = DEG_TO_RAD_Q36[31:16];

  localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CORDIC_W-1:0] ONE_Q30  = 34'sd1073741824;
  localparam logic [LEG_W-1:0]           LEG_MAX  = {LEG_W{1'b1}};
  localparam logic [TOTAL_W-1:0]         TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic [0:0] REG_RADIUS = 1'b0;
  localparam logic [0:0] REG_SPEED  = 1'b1;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctrl_t;

  function automatic logic [31:0] atan_q30(input logic [5:0] i);
    logic [31:0] v;
    v = 32'd0;
    unique case (i)
      6'd0: v = 32'd843314857;
      6'd1: v = 32'd497837829;
      6'd2: v = 32'd263043837;
      6'd3: v = 32'd133525159;
      6'd4: v = 32'd67021687;
      6'd5: v = 32'd33543516;
      6'd6: v = 32'd16775851;
      6'd7: v = 32'd8388437;
      6'd8: v = 32'd4194283;
      6'd9: v = 32'd2097149;
      default: begin
        if (i <= 6'd30) v = 32'd1 << (6'd30 - i);
        else v = 32'd0;
      end
    endcase
    return v;
  endfunction

  function automatic logic signed [OPND_W-1:0] clamp_unit(
      input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    if (v > ONE_Q30) r = ONE_Q30;
    else if (v < -ONE_Q30) r = -ONE_Q30;
    else r = v;
    return r[OPND_W-1:0];
  endfunction

endpackage

// ===== sv/rgca_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgca_cordic
// iterative cordic, one micro-rotation per cycle, rotation or vectoring mode
// ----------------------------------------------------------------------------
module rgca_cordic #(
  parameter int Iterations = rgca_pkg::CORDIC_ITERATIONS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  rgca_pkg::cordic_ctrl_t                 ctrl_i,
  input  logic signed [rgca_pkg::CORDIC_W-1:0]   x0_i,
  input  logic signed [rgca_pkg::CORDIC_W-1:0]   y0_i,
  input  logic signed [rgca_pkg::CORDIC_W-1:0]   z0_i,
  output logic                                   done_o,
  output logic signed [rgca_pkg::CORDIC_W-1:0]   x_o,
  output logic signed [rgca_pkg::CORDIC_W-1:0]   y_o,
  output logic signed [rgca_pkg::CORDIC_W-1:0]   z_o
);
  import rgca_pkg::*;

  localparam int IW = (Iterations > 1) ? $clog2(Iterations) : 1;
  localparam logic [IW-1:0] LAST = IW'(Iterations - 1);

  logic                       busy_q, done_q, vec_q;
  logic [IW-1:0]              cnt_q;
  logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
  logic signed [CORDIC_W-1:0] dx, dy, ang;
  logic                       dir;

  always_comb begin
    dx  = y_q >>> cnt_q;
    dy  = x_q >>> cnt_q;
    ang = $signed({2'b00, atan_q30(6'(cnt_q))});
    dir = vec_q ? !(y_q > 0) : (z_q >= 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      vec_q <= ctrl_i.vectoring;
      x_q   <= x0_i;
      y_q   <= y0_i;
      z_q   <= z0_i;
    end else if (busy_q) begin
      if (dir) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - ang;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + ang;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

// ===== sv/rgca_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgca_isqrt
// bit-serial floor square root, one result bit per cycle
// ----------------------------------------------------------------------------
module rgca_isqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rgca_pkg::ROOT_N_W-1:0]   n_i,
  output logic                            done_o,
  output logic [rgca_pkg::ROOT_W-1:0]     root_o
);
  import rgca_pkg::*;

  localparam logic [4:0] LAST = 5'(ROOT_W - 1);

  logic                  busy_q, done_q;
  logic [4:0]            cnt_q;
  logic [ROOT_N_W-1:0]   rem_q, res_q, bit_q;
  logic [ROOT_N_W:0]     trial;
  logic                  fits;

  always_comb begin
    trial = {1'b0, res_q} + {1'b0, bit_q};
    fits  = {1'b0, rem_q} >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= n_i;
      res_q <= '0;
      bit_q <= {1'b1, {(ROOT_N_W-1){1'b0}}};
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - trial[ROOT_N_W-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

// ===== sv/route_great_circle_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_great_circle_accumulator
// haversine leg distance over a waypoint stream with running route total
// and flight time
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_ready_o   latitude, longitude, route_start
//   out      source     out_valid_o / out_ready_i leg_valid, leg_distance,
//                                                 total_distance, total_time
//   cfg      sink       apb psel/penable/pwrite   earth_radius, cruise_speed
//
// the time a leg takes is set by the shared cordic, the serial root
// and the serial divider
// in_ready_o is high only while the sequencer is idle
// the result word sits in an output register, so a new word can be taken
// while the previous result waits; reset needs no clearing pass
// ----------------------------------------------------------------------------
module route_great_circle_accumulator #(
  parameter int CordicIterations = rgca_pkg::CORDIC_ITERATIONS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [rgca_pkg::LAT_W-1:0]    latitude_i,
  input  logic signed [rgca_pkg::LON_W-1:0]    longitude_i,
  input  logic                                 route_start_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 leg_valid_o,
  output logic [rgca_pkg::LEG_W-1:0]           leg_distance_o,
  output logic [rgca_pkg::TOTAL_W-1:0]         total_distance_o,
  output logic [rgca_pkg::TOTAL_W-1:0]         total_time_o
);
  import rgca_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_PREP = 5'd1;
  localparam logic [4:0] S_MLO  = 5'd2;
  localparam logic [4:0] S_MHI  = 5'd3;
  localparam logic [4:0] S_ZR   = 5'd4;
  localparam logic [4:0] S_ROT  = 5'd5;
  localparam logic [4:0] S_M1   = 5'd6;
  localparam logic [4:0] S_M2   = 5'd7;
  localparam logic [4:0] S_M3   = 5'd8;
  localparam logic [4:0] S_M4   = 5'd9;
  localparam logic [4:0] S_M5   = 5'd10;
  localparam logic [4:0] S_M6   = 5'd11;
  localparam logic [4:0] S_RT1  = 5'd12;
  localparam logic [4:0] S_RT2  = 5'd13;
  localparam logic [4:0] S_VEC  = 5'd14;
  localparam logic [4:0] S_LEG1 = 5'd15;
  localparam logic [4:0] S_LEG2 = 5'd16;
  localparam logic [4:0] S_DIV  = 5'd17;
  localparam logic [4:0] S_OUT  = 5'd18;

  localparam logic [1:0] CALL_DLAT = 2'd0;
  localparam logic [1:0] CALL_LAT1 = 2'd1;
  localparam logic [1:0] CALL_LAT2 = 2'd2;
  localparam logic [1:0] CALL_DLON = 2'd3;

  localparam int ZR_SHIFT = ANGLE_FRAC_BITS + 7;

  // configuration
  logic [RADIUS_W-1:0] radius_q;
  logic [SPEED_W-1:0]  speed_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_SPEED) ? {16'd0, speed_q} : {8'd0, radius_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
      speed_q  <= SPEED_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SPEED) speed_q <= pwdata[SPEED_W-1:0];
      else radius_q <= pwdata[RADIUS_W-1:0];
    end
  end

  // sequencer and route state
  logic [4:0]              state_q, state_d;
  logic [1:0]              call_q;
  logic [4:0]              div_cnt_q;
  logic                    have_prev_q, leg_valid_q;
  logic [TOTAL_W-1:0]      running_q;
  logic signed [LAT_W-1:0] lat_q, prev_lat_q;
  logic signed [LON_W-1:0] lon_q, prev_lon_q;
  logic                    out_valid_q;

  // datapath registers
  logic [MAG_W-1:0]         mag_q;
  logic                     neg_q, flip_q;
  logic [59:0]              acc_q;
  logic signed [PROD_W-1:0] p_q;
  logic signed [OPND_W-1:0] sd_q, c1_q, c2_q, s2_q, s1_q, cd_q, sq_q;
  logic [30:0]              h_q;
  logic [ROOT_W-1:0]        ysq_q;
  logic [31:0]              zang_q;
  logic [LEG_W-1:0]         leg_q;
  logic [SPEED_W-1:0]       rem_q;
  logic [TOTAL_W-1:0]       quo_q;
  logic [LEG_W-1:0]         out_leg_q;
  logic [TOTAL_W-1:0]       out_total_q, out_time_q;

  // shared multiplier
  logic signed [OPND_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] p_rnd;
  logic signed [OPND_W-1:0] rnd_v;

  // angle preparation
  logic signed [31:0] ang_a, ang_r, ang_f, ang_m;
  logic               ang_flip;

  logic [59:0]                zsum;
  logic [32:0]                zmag;
  logic signed [CORDIC_W-1:0] z_start;

  logic signed [CORDIC_W:0] h_sum;
  logic [30:0]              h_c;

  logic [TOTAL_W+1:0]  leg_full;
  logic [LEG_W-1:0]    leg_c;
  logic [TOTAL_W:0]    run_sum;
  logic [TOTAL_W-1:0]  run_new;

  logic [SPEED_W:0]    div_sh;
  logic                div_fit;

  // unit interfaces
  cordic_ctrl_t               cor_ctrl;
  logic signed [CORDIC_W-1:0] cor_x0, cor_y0, cor_z0, cor_x, cor_y, cor_z;
  logic                       cor_done;
  logic                       rt_start, rt_done;
  logic [ROOT_N_W-1:0]        rt_n;
  logic [ROOT_W-1:0]          rt_root;
  logic signed [OPND_W-1:0]   sin_c, cos_c;

  logic in_acc, out_load;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    ang_a = '0;
    unique case (call_q)
      CALL_DLAT: ang_a = 32'(lat_q) - 32'(prev_lat_q);
      CALL_LAT1: ang_a = 32'(prev_lat_q) <<< 1;
      CALL_LAT2: ang_a = 32'(lat_q) <<< 1;
      CALL_DLON: ang_a = 32'(lon_q) - 32'(prev_lon_q);
      default:   ang_a = '0;
    endcase
    if (ang_a >= HALF_TURN) ang_r = ang_a - FULL_TURN;
    else if (ang_a < -HALF_TURN) ang_r = ang_a + FULL_TURN;
    else ang_r = ang_a;
    ang_flip = 1'b1;
    if (ang_r > QUARTER_TURN) ang_f = HALF_TURN - ang_r;
    else if (ang_r < -QUARTER_TURN) ang_f = -HALF_TURN - ang_r;
    else begin
      ang_f    = ang_r;
      ang_flip = 1'b0;
    end
    ang_m = ang_f[31] ? -ang_f : ang_f;
  end

  always_comb begin
    zsum    = acc_q + {p_q[43:0], 16'd0} + (60'd1 << (ANGLE_FRAC_BITS + 6));
    zmag    = zsum[ZR_SHIFT+32:ZR_SHIFT];
    z_start = neg_q ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MLO: begin
        mul_a = $signed({5'd0, mag_q});
        mul_b = $signed({17'd0, DR_LO});
      end
      S_MHI: begin
        mul_a = $signed({5'd0, mag_q});
        mul_b = $signed({17'd0, DR_HI});
      end
      S_M1: begin
        mul_a = sd_q;
        mul_b = sd_q;
      end
      S_M2: begin
        mul_a = c1_q;
        mul_b = c2_q;
      end
      S_M3: begin
        mul_a = s2_q;
        mul_b = s2_q;
      end
      S_M5: begin
        mul_a = cd_q;
        mul_b = sq_q;
      end
      S_LEG1: begin
        mul_a = $signed({9'd0, radius_q});
        mul_b = $signed({1'b0, zang_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    p_rnd = p_q + $signed(PROD_W'(1) << 29);
    rnd_v = p_rnd[OPND_W+29:30];
  end

  always_comb begin
    h_sum = $signed({{2{s1_q[OPND_W-1]}}, s1_q}) + $signed({{2{rnd_v[OPND_W-1]}}, rnd_v});
    if (h_sum < 0) h_c = '0;
    else if (h_sum > 35'sd1073741824) h_c = 31'd1073741824;
    else h_c = h_sum[30:0];

    leg_full = p_q[TOTAL_W+1+29:29] + (TOTAL_W+2)'(p_q[28]);
    if (leg_full > (TOTAL_W+2)'(LEG_MAX)) leg_c = LEG_MAX;
    else leg_c = leg_full[LEG_W-1:0];
    run_sum = {1'b0, running_q} + (TOTAL_W+1)'(leg_c);
    run_new = run_sum[TOTAL_W] ? TOTAL_MAX : run_sum[TOTAL_W-1:0];

    div_sh  = {rem_q, quo_q[TOTAL_W-1]};
    div_fit = div_sh >= {1'b0, speed_q};

    sin_c = clamp_unit(cor_y);
    cos_c = flip_q ? -clamp_unit(cor_x) : clamp_unit(cor_x);
  end

  always_comb begin
    cor_ctrl.start     = 1'b0;
    cor_ctrl.vectoring = 1'b0;
    cor_x0   = GAIN_Q30;
    cor_y0   = '0;
    cor_z0   = z_start;
    rt_start = 1'b0;
    rt_n     = {h_c, 30'd0};
    unique case (state_q)
      S_ZR: cor_ctrl.start = 1'b1;
      S_M6: rt_start = 1'b1;
      S_RT1: begin
        rt_start = rt_done;
        rt_n     = {31'd1073741824 - h_q, 30'd0};
      end
      S_RT2: begin
        cor_ctrl.start     = rt_done;
        cor_ctrl.vectoring = 1'b1;
        cor_x0             = $signed({3'd0, rt_root});
        cor_y0             = $signed({3'd0, ysq_q});
        cor_z0             = '0;
      end
      default: begin
        cor_ctrl.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = (route_start_i || !have_prev_q) ? S_DIV : S_PREP;
      S_PREP: state_d = S_MLO;
      S_MLO:  state_d = S_MHI;
      S_MHI:  state_d = S_ZR;
      S_ZR:   state_d = S_ROT;
      S_ROT:  if (cor_done) state_d = (call_q == CALL_DLON) ? S_M1 : S_PREP;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = S_M3;
      S_M3:   state_d = S_M4;
      S_M4:   state_d = S_M5;
      S_M5:   state_d = S_M6;
      S_M6:   state_d = S_RT1;
      S_RT1:  if (rt_done) state_d = S_RT2;
      S_RT2:  if (rt_done) state_d = S_VEC;
      S_VEC:  if (cor_done) state_d = S_LEG1;
      S_LEG1: state_d = S_LEG2;
      S_LEG2: state_d = S_DIV;
      S_DIV:  if (div_cnt_q == 5'd31) state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      call_q      <= CALL_DLAT;
      div_cnt_q   <= '0;
      have_prev_q <= 1'b0;
      running_q   <= '0;
      prev_lat_q  <= '0;
      prev_lon_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        call_q    <= CALL_DLAT;
        div_cnt_q <= '0;
        if (route_start_i) begin
          running_q   <= '0;
          have_prev_q <= 1'b0;
        end
      end
      if (state_q == S_ROT && cor_done) call_q <= call_q + 2'd1;
      if (state_q == S_LEG2) running_q <= run_new;
      if (state_q == S_DIV) div_cnt_q <= div_cnt_q + 5'd1;
      if (out_load) begin
        out_valid_q <= 1'b1;
        prev_lat_q  <= lat_q;
        prev_lon_q  <= lon_q;
        have_prev_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    if (in_acc) begin
      lat_q       <= latitude_i;
      lon_q       <= longitude_i;
      leg_valid_q <= !route_start_i && have_prev_q;
      leg_q       <= '0;
      rem_q       <= '0;
      quo_q       <= route_start_i ? '0 : running_q;
    end
    if (state_q == S_PREP) begin
      mag_q  <= ang_m[MAG_W-1:0];
      neg_q  <= ang_f[31];
      flip_q <= ang_flip;
    end
    if (state_q == S_MHI) acc_q <= p_q[59:0];
    if (state_q == S_ROT && cor_done) begin
      unique case (call_q)
        CALL_DLAT: sd_q <= sin_c;
        CALL_LAT1: c1_q <= cos_c;
        CALL_LAT2: c2_q <= cos_c;
        CALL_DLON: s2_q <= sin_c;
        default:   sd_q <= sin_c;
      endcase
    end
    if (state_q == S_M2) s1_q <= rnd_v;
    if (state_q == S_M3) cd_q <= rnd_v;
    if (state_q == S_M4) sq_q <= rnd_v;
    if (state_q == S_M6) h_q <= h_c;
    if (state_q == S_RT1 && rt_done) ysq_q <= rt_root;
    if (state_q == S_VEC && cor_done) zang_q <= cor_z[CORDIC_W-1] ? 32'd0 : cor_z[31:0];
    if (state_q == S_LEG2) begin
      leg_q <= leg_c;
      rem_q <= '0;
      quo_q <= run_new;
    end
    if (state_q == S_DIV) begin
      rem_q <= div_fit ? 16'(div_sh - {1'b0, speed_q}) : div_sh[SPEED_W-1:0];
      quo_q <= {quo_q[TOTAL_W-2:0], div_fit};
    end
    if (out_load) begin
      out_leg_q   <= leg_q;
      out_total_q <= running_q;
      out_time_q  <= quo_q;
    end
  end

  logic out_leg_valid_q;
  always_ff @(posedge clk_i) begin
    if (out_load) out_leg_valid_q <= leg_valid_q;
  end

  rgca_cordic #(
    .Iterations(CordicIterations)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cor_ctrl),
    .x0_i   (cor_x0),
    .y0_i   (cor_y0),
    .z0_i   (cor_z0),
    .done_o (cor_done),
    .x_o    (cor_x),
    .y_o    (cor_y),
    .z_o    (cor_z)
  );

  rgca_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rt_start),
    .n_i     (rt_n),
    .done_o  (rt_done),
    .root_o  (rt_root)
  );

  assign out_valid_o      = out_valid_q;
  assign leg_valid_o      = out_leg_valid_q;
  assign leg_distance_o   = out_leg_q;
  assign total_distance_o = out_total_q;
  assign total_time_o     = out_time_q;

endmodule
